// ===== src/bmma_pkg.sv =====
// shared types, constants and helpers of the block matrix multiply-accumulate
package bmma_pkg;

  localparam int MAX_DIM     = 32;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int CNT_W       = $clog2(MAX_DIM);
  localparam int STORE_WORDS = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int WORD_W      = 32;
  localparam int CFG_W       = 6;
  localparam int MODE_W      = 3;
  localparam int INDEX_W     = 10;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // item modes
  localparam logic [MODE_W-1:0] MODE_WR_A  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RD_C  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLR_C = 3'd4;

  // register indexes
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [INDEX_W-1:0]        index;
    logic signed [WORD_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  read_value;
    logic                      op_done;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0] n1;
    logic [DIM_W-1:0] n2;
    logic [DIM_W-1:0] n3;
  } dims_t;

  typedef struct packed {
    logic a_we;
    logic b_we;
    logic c_sel_item;
    logic mac_init;
    logic mac_issue;
    logic clr_write;
    logic res_load;
    logic res_ok;
    logic res_from_c;
  } dp_cmd_t;

  typedef struct packed {
    logic mac_last;
    logic pipe_empty;
    logic clr_last;
    logic dim_zero;
  } dp_sts_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WIPE  = 6'b000010,
    S_CLEAR = 6'b000100,
    S_READ  = 6'b001000,
    S_MAC   = 6'b010000,
    S_DRAIN = 6'b100000
  } state_e;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    return (32'(d) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(d);
  endfunction

endpackage

// ===== src/bmma_ctrl.sv =====
// controller state machine of the block matrix multiply-accumulate
module bmma_ctrl import bmma_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  item_t   item_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;
  logic   in_range;

  assign in_range = 32'(item_i.index) < 32'(STORE_WORDS);
  assign busy_o   = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.c_sel_item = 1'b1;
        if (start_i) begin
          unique case (item_i.mode)
            MODE_WR_A: begin
              cmd_o.a_we     = in_range;
              cmd_o.res_load = 1'b1;
              cmd_o.res_ok   = in_range;
            end
            MODE_WR_B: begin
              cmd_o.b_we     = in_range;
              cmd_o.res_load = 1'b1;
              cmd_o.res_ok   = in_range;
            end
            MODE_MAC: begin
              if (sts_i.dim_zero) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_ok   = 1'b1;
              end else begin
                cmd_o.mac_init = 1'b1;
                state_d        = S_MAC;
              end
            end
            MODE_RD_C: begin
              if (in_range) begin
                state_d = S_READ;
              end else begin
                cmd_o.res_load = 1'b1;
              end
            end
            MODE_CLR_C: begin
              state_d = S_CLEAR;
            end
            default: begin
              cmd_o.res_load = 1'b1;
            end
          endcase
        end
      end
      S_WIPE: begin
        cmd_o.clr_write = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_ok   = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_ok     = 1'b1;
        cmd_o.res_from_c = 1'b1;
        state_d          = S_IDLE;
      end
      S_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (sts_i.mac_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_ok   = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WIPE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/bmma_dp.sv =====
// datapath: element stores, address counters, multiply-accumulate pipeline, result word
module bmma_dp import bmma_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  input  item_t   item_i,
  input  dims_t   dims_i,
  output dp_sts_t sts_o,
  output logic    res_valid_o,
  output result_t result_o
);

  logic [WORD_W-1:0] a_mem [STORE_WORDS];
  logic [WORD_W-1:0] b_mem [STORE_WORDS];
  logic [WORD_W-1:0] c_mem [STORE_WORDS];

  logic [ADDR_W-1:0] item_addr, c_raddr;
  logic [ADDR_W-1:0] n2_a, n3_a;

  // loop counters and running addresses
  logic [CNT_W-1:0]  k_q, j_q, i_q;
  logic [ADDR_W-1:0] a_row_q, a_addr_q, b_addr_q, c_addr_q, clr_q;
  logic              k_last, j_last, i_last, clr_last;

  // pipeline
  logic [WORD_W-1:0] a_rd_q, b_rd_q, c_rd_q, prod_q, c2_q, c3_q, sum_q;
  logic              v1_q, v2_q, wv3_q;
  logic              first1_q, first2_q, last1_q, last2_q;
  logic [ADDR_W-1:0] ca1_q, ca2_q, ca3_q;

  logic    res_valid_q;
  result_t res_q;

  assign item_addr = ADDR_W'(item_i.index);
  assign c_raddr   = cmd_i.c_sel_item ? item_addr : c_addr_q;
  assign n2_a      = ADDR_W'(dims_i.n2);
  assign n3_a      = ADDR_W'(dims_i.n3);

  assign k_last   = (DIM_W'(k_q) + DIM_W'(1)) == dims_i.n2;
  assign j_last   = (DIM_W'(j_q) + DIM_W'(1)) == dims_i.n3;
  assign i_last   = (DIM_W'(i_q) + DIM_W'(1)) == dims_i.n1;
  assign clr_last = clr_q == ADDR_W'(STORE_WORDS - 1);

  assign sts_o.mac_last   = k_last & j_last & i_last;
  assign sts_o.pipe_empty = !v1_q && !v2_q && !wv3_q;
  assign sts_o.clr_last   = clr_last;
  assign sts_o.dim_zero   = (dims_i.n1 == '0) || (dims_i.n2 == '0) || (dims_i.n3 == '0);

  // element stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.a_we) begin
      a_mem[item_addr] <= item_i.value;
    end
    a_rd_q <= a_mem[a_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.b_we) begin
      b_mem[item_addr] <= item_i.value;
    end
    b_rd_q <= b_mem[b_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_write) begin
      c_mem[clr_q] <= '0;
    end else if (wv3_q) begin
      c_mem[ca3_q] <= c3_q + sum_q;
    end
    c_rd_q <= c_mem[c_raddr];
  end

  // loop counters: k innermost, then column, then row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      j_q      <= '0;
      i_q      <= '0;
      a_row_q  <= '0;
      a_addr_q <= '0;
      b_addr_q <= '0;
      c_addr_q <= '0;
    end else if (cmd_i.mac_init) begin
      k_q      <= '0;
      j_q      <= '0;
      i_q      <= '0;
      a_row_q  <= '0;
      a_addr_q <= '0;
      b_addr_q <= '0;
      c_addr_q <= '0;
    end else if (cmd_i.mac_issue) begin
      if (!k_last) begin
        k_q      <= k_q + CNT_W'(1);
        a_addr_q <= a_addr_q + ADDR_W'(1);
        b_addr_q <= b_addr_q + n3_a;
      end else begin
        k_q      <= '0;
        c_addr_q <= c_addr_q + ADDR_W'(1);
        if (!j_last) begin
          j_q      <= j_q + CNT_W'(1);
          a_addr_q <= a_row_q;
          b_addr_q <= ADDR_W'(j_q) + ADDR_W'(1);
        end else begin
          j_q      <= '0;
          i_q      <= i_q + CNT_W'(1);
          a_row_q  <= a_row_q + n2_a;
          a_addr_q <= a_row_q + n2_a;
          b_addr_q <= '0;
        end
      end
    end
  end

  // clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_write) begin
      clr_q <= clr_last ? '0 : clr_q + ADDR_W'(1);
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      wv3_q <= 1'b0;
    end else begin
      v1_q  <= cmd_i.mac_issue;
      v2_q  <= v1_q;
      wv3_q <= v2_q & last2_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    first1_q <= k_q == '0;
    last1_q  <= k_last;
    ca1_q    <= c_addr_q;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    ca2_q    <= ca1_q;
    c2_q     <= c_rd_q;
    prod_q   <= a_rd_q * b_rd_q;
    ca3_q    <= ca2_q;
    c3_q     <= c2_q;
  end

  // dot product accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (v2_q) begin
      sum_q <= (first2_q ? '0 : sum_q) + prod_q;
    end
  end

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q.read_value <= cmd_i.res_from_c ? c_rd_q : '0;
      res_q.op_done    <= cmd_i.res_ok;
    end
  end

  assign res_valid_o = res_valid_q;
  assign result_o    = res_q;

endmodule

// ===== src/block_matrix_multiply_accumulate.sv =====
// top level: register port, controller and datapath of the block matrix multiply-accumulate
// write A/B and unused modes give their word in the cycle after accept, busy stays low
// read C: word follows the S_READ state and the registered C store read, busy while in S_READ
// accumulate: word once S_DRAIN finds the pipeline empty after S_MAC, busy meanwhile, one MAC per cycle
// clear C: one C entry zeroed per cycle through the store write port, busy until the last entry
// reset: a sweep zeros the C store with busy high; registers are taken meanwhile
// result words are strobed for one cycle and cannot be stalled by the receiver
module block_matrix_multiply_accumulate import bmma_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  item_t              item_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output result_t            result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [1:0]       reg_idx;
  logic             cfg_wr;
  dims_t            dims;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  // register port: always ready, written on the access cycle
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROWS_A:    rows_a_q    <= pwdata[CFG_W-1:0];
        REG_INNER_DIM: inner_dim_q <= pwdata[CFG_W-1:0];
        REG_COLS_B:    cols_b_q    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROWS_A:    prdata = PDATA_W'(rows_a_q);
      REG_INNER_DIM: prdata = PDATA_W'(inner_dim_q);
      REG_COLS_B:    prdata = PDATA_W'(cols_b_q);
      default:       prdata = '0;
    endcase
  end

  // dimensions above the store size saturate
  assign dims.n1 = clamp_dim(rows_a_q);
  assign dims.n2 = clamp_dim(inner_dim_q);
  assign dims.n3 = clamp_dim(cols_b_q);

  bmma_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  bmma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .dims_i      (dims),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .result_o    (result_o)
  );

  // single-cycle modes answer on the next cycle
  a_quick_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (item_i.mode == MODE_WR_A || item_i.mode == MODE_WR_B)
    |=> res_valid_o)
    else $error("write word missing");

  // only a completed read carries a nonzero value
  a_value_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && result_o.read_value != '0 |-> result_o.op_done)
    else $error("nonzero value without done");

  // the MAC pipeline is drained whenever new words may enter
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> sts.pipe_empty)
    else $error("pipeline busy while idle");

  // an accumulate with live dimensions holds off new words
  a_mac_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.mode == MODE_MAC && !sts.dim_zero |=> busy_o && !res_valid_o)
    else $error("accumulate did not start");

endmodule
